// ===== design/midi_cc_router_with_learn_defines.svh =====
// Assertion macros for the control-change router
`ifndef MIDI_CC_ROUTER_WITH_LEARN_DEFINES_SVH
`define MIDI_CC_ROUTER_WITH_LEARN_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MCR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// next-cycle implication
`define MCR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// ===== design/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Types and constants of the control-change router.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mcr_pkg;
	localparam int ROUTE_SLOTS_DEF   = 32;
	localparam int LEARN_TOUCHES_DEF = 8;
	localparam int CONTROL_COUNT     = 128;
	localparam logic [6:0] MIDI_MAX  = 7'd127;

	localparam logic [2:0] MODE_EVENT    = 3'd0;
	localparam logic [2:0] MODE_REGISTER = 3'd1;
	localparam logic [2:0] MODE_REMOVE   = 3'd2;
	localparam logic [2:0] MODE_SET_KIND = 3'd3;
	localparam logic [2:0] MODE_LEARN    = 3'd4;

	localparam logic [2:0] RK_OK    = 3'd0;
	localparam logic [2:0] RK_ERROR = 3'd1;
	localparam logic [2:0] RK_LEVEL = 3'd2;
	localparam logic [2:0] RK_TICK  = 3'd3;
	localparam logic [2:0] RK_LEARN = 3'd4;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_BAD_CTRL = 3'd1;
	localparam logic [2:0] ST_NULL     = 3'd2;
	localparam logic [2:0] ST_ROUTED   = 3'd3;
	localparam logic [2:0] ST_NO_TYPE  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic [1:0] KIND_UNDEF = 2'd0;
	localparam logic [1:0] KIND_CONT  = 2'd1;
	localparam logic [1:0] KIND_DISC  = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] control_number;
		logic [6:0] level;
		logic [9:0] component_id;
		logic [7:0] param_id;
		logic       kind_select;
		logic       learn_enable;
	} req_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [2:0] status;
		logic [9:0] dest_component;
		logic [7:0] dest_param;
		logic [6:0] level_out;
		logic [6:0] learned_control;
		logic       learned_kind;
		logic       last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch request, clear scan flags
		logic scan;      // examine slot at scan index
		logic reg_write; // write route into free slot
		logic kind_rd;   // read control kind
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       scan_done;
		logic       hit;       // current slot matches event
		logic       dup;
		logic       has_free;
		logic [1:0] kind;
	} sts_t;
endpackage

// ===== design/midi_cc_router_with_learn.sv =====
// ----------------------------------------------------------------------------
// midi_cc_router_with_learn
// MIDI control-change router with route table and learn mode.
// ----------------------------------------------------------------------------
// One request at a time. Every request passes KREAD and DECODE; set-type
// and set-learning requests, a register request rejected for a bad control
// or a null component, and a learn touch that classifies then end in FINISH,
// and an event that yields nothing without a scan returns to IDLE. Register
// and remove requests scan the route table one slot per cycle, then pass
// EMIT and FINISH; a routed event scans the same way, with the scan held
// while a result waits downstream, and ends in FINISH, or returns to IDLE
// when no slot matches.
`timescale 1ns / 1ps
module midi_cc_router_with_learn #(
	parameter int ROUTE_SLOTS   = mcr_pkg::ROUTE_SLOTS_DEF,
	parameter int LEARN_TOUCHES = mcr_pkg::LEARN_TOUCHES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mcr_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mcr_pkg::rsp_t out_data
);
	mcr_pkg::cmd_t cmd;
	mcr_pkg::sts_t sts;
	mcr_pkg::req_t req_q;
	logic [9:0] hit_component;
	logic [7:0] hit_param;
	logic set_kind_we;
	logic [6:0] set_kind_addr;
	logic [1:0] set_kind_val;

	mcr_dp #(.ROUTE_SLOTS(ROUTE_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd),
		.set_kind_we(set_kind_we), .set_kind_addr(set_kind_addr),
		.set_kind_val(set_kind_val), .sts(sts), .hit_component(hit_component),
		.hit_param(hit_param), .req_q(req_q)
	);

	mcr_ctrl #(.LEARN_TOUCHES(LEARN_TOUCHES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .rsp(out_data),
		.req_q(req_q), .sts(sts), .hit_component(hit_component),
		.hit_param(hit_param), .cmd(cmd), .set_kind_we(set_kind_we),
		.set_kind_addr(set_kind_addr), .set_kind_val(set_kind_val)
	);
endmodule

// ===== design/mcr_dp.sv =====
// ----------------------------------------------------------------------------
// mcr_dp
// Route table, control kinds and the slot scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcr_dp #(
	parameter int ROUTE_SLOTS = mcr_pkg::ROUTE_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mcr_pkg::req_t req,
	input  mcr_pkg::cmd_t cmd,
	input  logic          set_kind_we,
	input  logic [6:0]    set_kind_addr,
	input  logic [1:0]    set_kind_val,
	output mcr_pkg::sts_t sts,
	output logic [9:0]    hit_component,
	output logic [7:0]    hit_param,
	output mcr_pkg::req_t req_q
);
	localparam int SW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam int CW = $clog2(ROUTE_SLOTS + 1);

	logic [ROUTE_SLOTS-1:0] valid_q;
	logic [6:0] ctrl_q [ROUTE_SLOTS];
	logic [9:0] comp_q [ROUTE_SLOTS];
	logic [7:0] par_q  [ROUTE_SLOTS];
	logic [1:0] kind_q [mcr_pkg::CONTROL_COUNT];
	logic [mcr_pkg::CONTROL_COUNT-1:0] kind_set_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] free_q;
	logic dup_q, has_free_q;
	logic [1:0] kind_rd_q;
	logic [SW-1:0] idx;
	logic dest_eq;

	assign idx = idx_q[SW-1:0];
	assign dest_eq = valid_q[idx] && comp_q[idx] == req_q.component_id
		&& par_q[idx] == req_q.param_id;

	always_ff @(posedge clk) begin
		if (set_kind_we) kind_q[set_kind_addr] <= set_kind_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			req_q <= '0;
			idx_q <= '0;
			dup_q <= 1'b0;
			has_free_q <= 1'b0;
			free_q <= '0;
			kind_rd_q <= mcr_pkg::KIND_UNDEF;
			kind_set_q <= '0;
		end else begin
			if (cmd.load) begin
				req_q <= req;
				idx_q <= '0;
				dup_q <= 1'b0;
				has_free_q <= 1'b0;
			end
			if (cmd.kind_rd) kind_rd_q <= kind_set_q[req_q.control_number[6:0]]
				? kind_q[req_q.control_number[6:0]] : mcr_pkg::KIND_UNDEF;
			if (cmd.scan && idx_q < CW'(ROUTE_SLOTS)) begin
				idx_q <= idx_q + 1'b1;
				if (dest_eq) begin
					dup_q <= 1'b1;
					if (req_q.mode == mcr_pkg::MODE_REMOVE) valid_q[idx] <= 1'b0;
				end
				if (!valid_q[idx] && !has_free_q) begin
					has_free_q <= 1'b1;
					free_q <= idx;
				end
			end
			if (cmd.reg_write) begin
				valid_q[free_q] <= 1'b1;
				ctrl_q[free_q] <= req_q.control_number[6:0];
				comp_q[free_q] <= req_q.component_id;
				par_q[free_q] <= req_q.param_id;
			end
			if (set_kind_we) kind_set_q[set_kind_addr] <= 1'b1;
		end
	end

	assign sts.scan_done = idx_q >= CW'(ROUTE_SLOTS);
	assign sts.hit = !sts.scan_done && valid_q[idx]
		&& ctrl_q[idx] == req_q.control_number[6:0];
	assign sts.dup = dup_q;
	assign sts.has_free = has_free_q;
	assign sts.kind = kind_rd_q;
	assign hit_component = comp_q[idx];
	assign hit_param = par_q[idx];
endmodule

// ===== design/mcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcr_ctrl
// Sequencer: decodes the request, runs the scan, forms results, learn logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_cc_router_with_learn_defines.svh"
module mcr_ctrl #(
	parameter int LEARN_TOUCHES = mcr_pkg::LEARN_TOUCHES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output mcr_pkg::rsp_t rsp,
	input  mcr_pkg::req_t req_q,
	input  mcr_pkg::sts_t sts,
	input  logic [9:0]    hit_component,
	input  logic [7:0]    hit_param,
	output mcr_pkg::cmd_t cmd,
	output logic          set_kind_we,
	output logic [6:0]    set_kind_addr,
	output logic [1:0]    set_kind_val
);
	typedef enum logic [2:0] {IDLE, KREAD, DECODE, SCAN, EMIT, FINISH} state_t;
	state_t state_q;
	logic learning_q, mixed_q;
	logic [3:0] count_q;
	logic [6:0] tctrl_q;
	logic pend_q;
	logic reg_write_q;
	mcr_pkg::rsp_t hold_q;
	logic [6:0] lvl;
	logic bad;

	assign lvl = req_q.level;
	assign bad = req_q.control_number[7];
	assign in_ready = state_q == IDLE;
	assign cmd.load = in_valid && in_ready;
	assign cmd.kind_rd = state_q == KREAD;
	assign cmd.scan = state_q == SCAN && !(out_valid && !out_ready);
	assign cmd.reg_write = reg_write_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			learning_q <= 1'b0;
			mixed_q <= 1'b0;
			count_q <= '0;
			tctrl_q <= '0;
			pend_q <= 1'b0;
			hold_q <= '0;
			reg_write_q <= 1'b0;
			set_kind_we <= 1'b0;
			set_kind_addr <= '0;
			set_kind_val <= '0;
			rsp <= '0;
		end else begin
			reg_write_q <= 1'b0;
			set_kind_we <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (cmd.load) state_q <= KREAD;
				end
				KREAD: state_q <= DECODE;
				DECODE: begin
					state_q <= IDLE;
					rsp <= '0;
					rsp.last <= 1'b1;
					case (req_q.mode)
						mcr_pkg::MODE_EVENT: begin
							if (bad) state_q <= IDLE;
							else if (learning_q) begin
								if (count_q == '0 || req_q.control_number[6:0] != tctrl_q) begin
									tctrl_q <= req_q.control_number[6:0];
									mixed_q <= !(lvl == '0 || lvl == mcr_pkg::MIDI_MAX);
									count_q <= 4'd1;
								end else if (count_q < 4'(LEARN_TOUCHES)) begin
									if (!(lvl == '0 || lvl == mcr_pkg::MIDI_MAX)) mixed_q <= 1'b1;
									count_q <= count_q + 4'd1;
								end else begin
									set_kind_we <= 1'b1;
									set_kind_addr <= req_q.control_number[6:0];
									set_kind_val <= mixed_q ? mcr_pkg::KIND_CONT
										: mcr_pkg::KIND_DISC;
									rsp.result_kind <= mcr_pkg::RK_LEARN;
									rsp.learned_control <= req_q.control_number[6:0];
									rsp.learned_kind <= !mixed_q;
									out_valid <= 1'b1;
									count_q <= '0;
									mixed_q <= 1'b0;
									learning_q <= 1'b0;
									state_q <= FINISH;
								end
							end else if (sts.kind == mcr_pkg::KIND_CONT
								|| (sts.kind == mcr_pkg::KIND_DISC && lvl == '0)) begin
								pend_q <= 1'b0;
								state_q <= SCAN;
							end
						end
						mcr_pkg::MODE_REGISTER: begin
							if (bad) begin
								rsp.result_kind <= mcr_pkg::RK_ERROR;
								rsp.status <= mcr_pkg::ST_BAD_CTRL;
								out_valid <= 1'b1;
								state_q <= FINISH;
							end else if (req_q.component_id == '0) begin
								rsp.result_kind <= mcr_pkg::RK_ERROR;
								rsp.status <= mcr_pkg::ST_NULL;
								out_valid <= 1'b1;
								state_q <= FINISH;
							end else state_q <= SCAN;
						end
						mcr_pkg::MODE_REMOVE: state_q <= SCAN;
						mcr_pkg::MODE_SET_KIND: begin
							if (bad) begin
								rsp.result_kind <= mcr_pkg::RK_ERROR;
								rsp.status <= mcr_pkg::ST_BAD_CTRL;
							end else begin
								set_kind_we <= 1'b1;
								set_kind_addr <= req_q.control_number[6:0];
								set_kind_val <= req_q.kind_select ? mcr_pkg::KIND_DISC
									: mcr_pkg::KIND_CONT;
							end
							out_valid <= 1'b1;
							state_q <= FINISH;
						end
						mcr_pkg::MODE_LEARN: begin
							learning_q <= req_q.learn_enable;
							out_valid <= 1'b1;
							state_q <= FINISH;
						end
						default: state_q <= IDLE;
					endcase
				end
				SCAN: begin
					if (req_q.mode == mcr_pkg::MODE_EVENT) begin
						if (cmd.scan && sts.hit) begin
							// park the hit; release the one parked before as not last
							if (pend_q) begin
								rsp <= hold_q;
								out_valid <= 1'b1;
							end
							pend_q <= 1'b1;
							hold_q <= '0;
							hold_q.result_kind <= sts.kind == mcr_pkg::KIND_CONT
								? mcr_pkg::RK_LEVEL : mcr_pkg::RK_TICK;
							hold_q.dest_component <= hit_component;
							hold_q.dest_param <= hit_param;
							hold_q.level_out <= sts.kind == mcr_pkg::KIND_CONT ? lvl : '0;
						end else if (cmd.scan && sts.scan_done) begin
							if (pend_q) begin
								rsp <= hold_q;
								rsp.last <= 1'b1;
								out_valid <= 1'b1;
								state_q <= FINISH;
							end else state_q <= IDLE;
						end
					end else if (sts.scan_done) state_q <= EMIT;
				end
				EMIT: begin
					rsp <= '0;
					rsp.last <= 1'b1;
					if (req_q.mode == mcr_pkg::MODE_REGISTER) begin
						if (sts.dup) begin
							rsp.result_kind <= mcr_pkg::RK_ERROR;
							rsp.status <= mcr_pkg::ST_ROUTED;
						end else if (sts.kind == mcr_pkg::KIND_UNDEF) begin
							rsp.result_kind <= mcr_pkg::RK_ERROR;
							rsp.status <= mcr_pkg::ST_NO_TYPE;
						end else if (!sts.has_free) begin
							rsp.result_kind <= mcr_pkg::RK_ERROR;
							rsp.status <= mcr_pkg::ST_FULL;
						end else reg_write_q <= 1'b1;
					end
					out_valid <= 1'b1;
					state_q <= FINISH;
				end
				FINISH: begin
					if (!out_valid || out_ready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`MCR_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid || state_q == IDLE)
	`MCR_ASSERT_NXT(a_load_kread, clk, arst_n, cmd.load, state_q == KREAD)
	`MCR_ASSERT_IMP(a_learn_last, clk, arst_n,
		out_valid && rsp.result_kind == mcr_pkg::RK_LEARN, rsp.last)
	`MCR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rsp))
endmodule
